[sv/vqr_pkg.sv]
`default_nettype none
package vqr_pkg;

	localparam int SampleW = 24;
	localparam int RatioW  = 16;
	localparam int GainW   = 16;
	localparam int PanW    = 16;

	// shared multiplier operand and product widths
	localparam int MulAW = 28;
	localparam int MulBW = 19;
	localparam int MulPW = MulAW + MulBW;

	localparam int AddrW = 3;
	localparam int DataW = 32;

	// register indexes, taken from paddr[2]
	localparam logic RegPan    = 1'b0;
	localparam logic RegStereo = 1'b1;

	localparam logic [PanW-1:0] PanReset    = 16'd32768;
	localparam logic            StereoReset = 1'b1;

	typedef struct packed {
		logic [PanW-1:0] pan_left;
		logic            stereo_out;
	} cfg_t;

endpackage
`default_nettype wire

[sv/variable_rate_quadratic_resampler.sv]
`default_nettype none
// Variable-ratio resampler: each input item shifts one sample into a three-sample
// history and yields up to 17 output items by three-point quadratic interpolation,
// scaled by gain and split by pan_left (stereo_out = 1) or sent mono to left.
// One 28x19 multiplier is shared by all products under a small sequencer, so
// in_stall stays high while an item is worked on: each output item runs PREP,
// M1 to M4 (plus M5, M6 in stereo) and EMIT, where it waits on out_stall; an
// item that gives no output goes from PREP back to idle. The output register
// lets the next item be taken while the last result still waits. Registers on
// the APB port: pan_left at 0x0 (reset 32768), stereo_out at 0x4 (reset 1).
module variable_rate_quadratic_resampler (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic        [vqr_pkg::AddrW-1:0]   paddr,
	input  wire logic        [vqr_pkg::DataW-1:0]   pwdata,
	output logic             [vqr_pkg::DataW-1:0]   prdata,
	output logic                                    pready,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic signed [vqr_pkg::SampleW-1:0] sample,
	input  wire logic        [vqr_pkg::RatioW-1:0]  pitch_ratio,
	input  wire logic        [vqr_pkg::GainW-1:0]   gain,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic signed      [vqr_pkg::SampleW-1:0] left,
	output logic signed      [vqr_pkg::SampleW-1:0] right,
	output logic                                    last
);
	import vqr_pkg::*;

	cfg_t cfg;

	vqr_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	vqr_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample      (sample),
		.pitch_ratio (pitch_ratio),
		.gain        (gain),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.left        (left),
		.right       (right),
		.last        (last)
	);

endmodule
`default_nettype wire

[sv/vqr_apb.sv]
`default_nettype none
module vqr_apb (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [vqr_pkg::AddrW-1:0] paddr,
	input  wire logic [vqr_pkg::DataW-1:0] pwdata,
	output logic      [vqr_pkg::DataW-1:0] prdata,
	output logic                           pready,
	output vqr_pkg::cfg_t                  cfg
);
	import vqr_pkg::*;

	cfg_t cfg_q;
	logic wr;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pan_left   <= PanReset;
			cfg_q.stereo_out <= StereoReset;
		end else if (wr) begin
			unique case (paddr[2])
				RegPan:    cfg_q.pan_left   <= pwdata[PanW-1:0];
				RegStereo: cfg_q.stereo_out <= pwdata[0];
				default:   cfg_q            <= cfg_q;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			unique case (paddr[2])
				RegPan:    prdata = {{(DataW-PanW){1'b0}}, cfg_q.pan_left};
				RegStereo: prdata = {{(DataW-1){1'b0}}, cfg_q.stereo_out};
				default:   prdata = '0;
			endcase
		end
	end

endmodule
`default_nettype wire

[sv/vqr_mul.sv]
`default_nettype none
module vqr_mul (
	input  wire logic signed [vqr_pkg::MulAW-1:0] a,
	input  wire logic signed [vqr_pkg::MulBW-1:0] b,
	output logic signed      [vqr_pkg::MulPW-1:0] p
);
	import vqr_pkg::*;

	logic signed [MulPW-1:0] a_ext;
	logic signed [MulPW-1:0] b_ext;

	assign a_ext = {{MulBW{a[MulAW-1]}}, a};
	assign b_ext = {{MulAW{b[MulBW-1]}}, b};
	assign p     = a_ext * b_ext;

endmodule
`default_nettype wire

[sv/vqr_core.sv]
`default_nettype none
module vqr_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  vqr_pkg::cfg_t                           cfg,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic signed [vqr_pkg::SampleW-1:0] sample,
	input  wire logic        [vqr_pkg::RatioW-1:0]  pitch_ratio,
	input  wire logic        [vqr_pkg::GainW-1:0]   gain,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic signed      [vqr_pkg::SampleW-1:0] left,
	output logic signed      [vqr_pkg::SampleW-1:0] right,
	output logic                                    last
);
	import vqr_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_PREP = 4'd1;
	localparam logic [3:0] S_M1   = 4'd2;
	localparam logic [3:0] S_M2   = 4'd3;
	localparam logic [3:0] S_M3   = 4'd4;
	localparam logic [3:0] S_M4   = 4'd5;
	localparam logic [3:0] S_M5   = 4'd6;
	localparam logic [3:0] S_M6   = 4'd7;
	localparam logic [3:0] S_EMIT = 4'd8;

	localparam int MaxFrames = 17;
	localparam logic [4:0] LastFrame = 5'(MaxFrames - 1);
	localparam logic [17:0] TMax = 18'd196608;
	localparam logic signed [32:0] SatMax = 33'sd8388607;
	localparam logic signed [32:0] SatMin = -33'sd8388608;
	localparam logic signed [23:0] PosMax = 24'sh7FFFFF;
	localparam logic signed [23:0] PosMin = -24'sd8388608;

	logic [3:0] state_q;
	logic [4:0] n_q;
	logic signed [23:0] y0_q, y1_q, y2_q, pos_q;
	logic [RatioW-1:0] ratio_q;
	logic [GainW-1:0] gain_q;
	logic signed [27:0] b2_q, c2_q, y_q;
	logic [17:0] t_q;
	logic signed [44:0] inner_q;
	logic signed [MulPW-1:0] acc_q;
	logic signed [43:0] g_q;
	logic signed [59:0] gp_q;
	logic out_valid_q, last_q;
	logic signed [23:0] left_q, right_q;

	logic signed [MulAW-1:0] mul_a;
	logic signed [MulBW-1:0] mul_b;
	logic signed [MulPW-1:0] mul_p;

	logic signed [27:0] y0e, y1e, y2e, b2_d, c2_d;
	logic signed [24:0] tsum, pos_dec, pos_inc;
	logic [17:0] t_d;
	logic signed [23:0] pos_in, pos_next;
	logic signed [63:0] v_d;
	logic signed [44:0] gm;
	logic signed [59:0] gl, gr;
	logic signed [23:0] l_d, r_d;
	logic accept, can_load, cont;

	function automatic logic signed [23:0] sat24(input logic signed [32:0] v);
		logic signed [23:0] r;
		if (v > SatMax) r = PosMax;
		else if (v < SatMin) r = PosMin;
		else r = v[23:0];
		return r;
	endfunction

	function automatic logic signed [23:0] sat25(input logic signed [24:0] v);
		logic signed [23:0] r;
		if (v[24] != v[23]) r = v[24] ? PosMin : PosMax;
		else r = v[23:0];
		return r;
	endfunction

	vqr_mul u_mul (
		.a (mul_a),
		.b (mul_b),
		.p (mul_p)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid & ~in_stall;
	assign can_load  = ~out_valid_q | ~out_stall;
	assign out_valid = out_valid_q;
	assign left      = left_q;
	assign right     = right_q;
	assign last      = last_q;

	// quadratic coefficients from the history
	assign y0e  = {{4{y0_q[23]}}, y0_q};
	assign y1e  = {{4{y1_q[23]}}, y1_q};
	assign y2e  = {{4{y2_q[23]}}, y2_q};
	assign b2_d = (y1e <<< 2) - y0e - (y0e <<< 1) - y2e;
	assign c2_d = y0e - (y1e <<< 1) + y2e;

	// interpolation point t = pos + 2, clamped to [0, 3]
	assign tsum = {pos_q[23], pos_q} + 25'sd131072;
	always_comb begin
		if (tsum < 25'sd0) t_d = '0;
		else if (tsum > $signed({7'b0, TMax})) t_d = TMax;
		else t_d = tsum[17:0];
	end

	assign pos_dec  = {pos_q[23], pos_q} - 25'sd65536;
	assign pos_in   = sat25(pos_dec);
	assign pos_inc  = {pos_q[23], pos_q} + $signed({5'b0, ratio_q, 4'b0});
	assign pos_next = sat25(pos_inc);
	assign cont     = (pos_next < -24'sd32768) && (n_q != LastFrame);

	// high partial product of inner * t joins y0 * 2^33 and the low partial
	assign v_d = {{7{y0_q[23]}}, y0_q, 33'b0} + {mul_p[40:0], 23'b0}
		+ {{(64-MulPW){acc_q[MulPW-1]}}, acc_q} + {31'b0, 1'b1, 32'b0};

	assign gm = {g_q[43], g_q} + 45'sd2048;
	assign gl = gp_q + 60'sd134217728;
	assign gr = {g_q, 16'b0} - gp_q + 60'sd134217728;

	always_comb begin
		if (cfg.stereo_out) begin
			l_d = sat24({gl[59], gl[59:28]});
			r_d = sat24({gr[59], gr[59:28]});
		end else begin
			l_d = sat24(gm[44:12]);
			r_d = '0;
		end
	end

	always_comb begin
		unique case (state_q)
			S_M1: begin
				mul_a = c2_q;
				mul_b = {1'b0, t_q};
			end
			S_M2: begin
				mul_a = {5'b0, inner_q[22:0]};
				mul_b = {1'b0, t_q};
			end
			S_M3: begin
				mul_a = {{6{inner_q[44]}}, inner_q[44:23]};
				mul_b = {1'b0, t_q};
			end
			S_M4: begin
				mul_a = y_q;
				mul_b = {3'b0, gain_q};
			end
			S_M5: begin
				mul_a = {6'b0, g_q[21:0]};
				mul_b = {3'b0, cfg.pan_left};
			end
			S_M6: begin
				mul_a = {{6{g_q[43]}}, g_q[43:22]};
				mul_b = {3'b0, cfg.pan_left};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			n_q         <= '0;
			y0_q        <= '0;
			y1_q        <= '0;
			y2_q        <= '0;
			pos_q       <= -24'sd65536;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_EMIT && can_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						y0_q    <= y1_q;
						y1_q    <= y2_q;
						y2_q    <= sample;
						pos_q   <= pos_in;
						n_q     <= '0;
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					if (pos_q >= 24'sd32768) state_q <= S_IDLE;
					else state_q <= S_M1;
				end
				S_M1: state_q <= S_M2;
				S_M2: state_q <= S_M3;
				S_M3: state_q <= S_M4;
				S_M4: state_q <= cfg.stereo_out ? S_M5 : S_EMIT;
				S_M5: state_q <= S_M6;
				S_M6: state_q <= S_EMIT;
				S_EMIT: begin
					if (can_load) begin
						pos_q   <= pos_next;
						n_q     <= n_q + 5'd1;
						state_q <= cont ? S_PREP : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ratio_q <= pitch_ratio;
			gain_q  <= gain;
		end
		unique case (state_q)
			S_PREP: begin
				b2_q <= b2_d;
				c2_q <= c2_d;
				t_q  <= t_d;
			end
			S_M1: inner_q <= {b2_q[27], b2_q, 16'b0} + mul_p[44:0];
			S_M2: acc_q <= mul_p;
			S_M3: y_q <= v_d[60:33];
			S_M4: g_q <= mul_p[43:0];
			S_M5: acc_q <= mul_p;
			S_M6: gp_q <= {mul_p[37:0], 22'b0} + {{(60-MulPW){acc_q[MulPW-1]}}, acc_q};
			S_EMIT: begin
				if (can_load) begin
					left_q  <= l_d;
					right_q <= r_d;
					last_q  <= ~cont;
				end
			end
			default: begin
			end
		endcase
	end

	a_frame_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= LastFrame + 5'd1)
		else $error("frame count beyond cap");

	a_loop_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PREP && $past(state_q) == S_EMIT) |-> pos_q < -24'sd32768)
		else $error("frame loop continued with position out of range");

	a_emit_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_valid_q && out_stall) |=> state_q == S_EMIT)
		else $error("frame dropped while output register full");

	a_t_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_M1) |-> t_q <= TMax)
		else $error("interpolation point out of range");

endmodule
`default_nettype wire
